// ===== sv/pli_pkg.sv =====
// ---------------------------------------------------------------------------
// pli_pkg
// shared constants, codes and types of the piecewise linear table interpolator
// ---------------------------------------------------------------------------
package pli_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned COMPONENTS  = 9;
  localparam int unsigned FRAC_BITS   = 16;

  // component ports on each beat
  localparam int unsigned MAX_COMP = 9;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DIFF_W = VAL_W + 1;
  localparam int unsigned PROD_W = FRAC_BITS + 1 + DIFF_W;
  localparam int unsigned DCNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [1:0] {
    LS_STORED = 2'd0,
    LS_SKIP   = 2'd1,
    LS_FULL   = 2'd2
  } load_status_e;

  typedef enum logic [1:0] {
    QR_INSIDE = 2'd0,
    QR_LOW    = 2'd1,
    QR_HIGH   = 2'd2,
    QR_EMPTY  = 2'd3
  } query_range_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // control from the sequencer to every lane
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic             cap0;
    logic             cap1;
    logic             mul;
    logic             fin;
  } lane_ctrl_t;

endpackage

// ===== sv/pli_ram.sv =====
// ---------------------------------------------------------------------------
// pli_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module pli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pli_div.sv =====
// ---------------------------------------------------------------------------
// pli_div
// restoring divider, one quotient bit per cycle, fraction of a segment
// ---------------------------------------------------------------------------
module pli_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pli_pkg::DIFF_W-1:0]     num_i,
  input  logic [pli_pkg::DIFF_W-1:0]     den_i,
  output logic                           done_o,
  output logic [pli_pkg::FRAC_BITS-1:0]  quo_o
);

  logic [pli_pkg::DIFF_W-1:0]    rem_q, rem_d;
  logic [pli_pkg::DIFF_W-1:0]    den_q;
  logic [pli_pkg::FRAC_BITS-1:0] quo_q;
  logic [pli_pkg::DCNT_W-1:0]    cnt_q;
  logic                          busy_q, done_q;
  logic [pli_pkg::DIFF_W:0]      rem2, sub;
  logic                          ge;

  assign rem2  = {rem_q, 1'b0};
  assign ge    = rem2 >= {1'b0, den_q};
  assign sub   = rem2 - {1'b0, den_q};
  assign rem_d = ge ? sub[pli_pkg::DIFF_W-1:0] : rem2[pli_pkg::DIFF_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= pli_pkg::DCNT_W'(pli_pkg::FRAC_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == pli_pkg::DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[pli_pkg::FRAC_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/pli_lane.sv =====
// ---------------------------------------------------------------------------
// pli_lane
// one component lane: component memory, difference, product and sum
// ---------------------------------------------------------------------------
module pli_lane (
  input  logic                          clk_i,
  input  pli_pkg::lane_ctrl_t           ctrl_i,
  input  logic [pli_pkg::VAL_W-1:0]     wdata_i,
  input  logic [pli_pkg::FRAC_BITS-1:0] frac_i,
  output logic [pli_pkg::VAL_W-1:0]     res_o
);

  logic [pli_pkg::VAL_W-1:0]         rdata;
  logic signed [pli_pkg::VAL_W-1:0]  v0_q, v1_q;
  logic signed [pli_pkg::DIFF_W-1:0] diff;
  logic signed [pli_pkg::PROD_W-1:0] prod_q, sum;
  logic [pli_pkg::VAL_W-1:0]         res_q;

  pli_ram #(
    .WIDTH (pli_pkg::VAL_W),
    .DEPTH (pli_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.we),
    .waddr_i (ctrl_i.waddr),
    .wdata_i (wdata_i),
    .raddr_i (ctrl_i.raddr),
    .rdata_o (rdata)
  );

  assign diff = pli_pkg::DIFF_W'(v1_q) - pli_pkg::DIFF_W'(v0_q);
  // arithmetic shift floors toward minus infinity
  assign sum  = pli_pkg::PROD_W'(v0_q) + (prod_q >>> pli_pkg::FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap0) v0_q <= rdata;
    if (ctrl_i.cap1) v1_q <= rdata;
    if (ctrl_i.mul) begin
      prod_q <= $signed({1'b0, frac_i}) * diff;
    end
    if (ctrl_i.fin) res_q <= sum[pli_pkg::VAL_W-1:0];
  end

  assign res_o = res_q;

endmodule

// ===== sv/piecewise_linear_table_interp_core.sv =====
// ---------------------------------------------------------------------------
// piecewise_linear_table_interp_core
// stamp table with nine parallel component lanes and linear interpolation
// ---------------------------------------------------------------------------
// a load goes through the load and final states to its result beat; a query
// goes through the range check, the binary search, the bit serial divider and
// the lane and output states; clamped queries skip search and divider, empty
// queries also skip the lanes; one item at a time, next beat taken the cycle
// after the result is registered; reset empties the table
module piecewise_linear_table_interp_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] stamp_i,
  input  logic [31:0] comp_0_i,
  input  logic [31:0] comp_1_i,
  input  logic [31:0] comp_2_i,
  input  logic [31:0] comp_3_i,
  input  logic [31:0] comp_4_i,
  input  logic [31:0] comp_5_i,
  input  logic [31:0] comp_6_i,
  input  logic [31:0] comp_7_i,
  input  logic [31:0] comp_8_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_0_o,
  output logic [31:0] out_1_o,
  output logic [31:0] out_2_o,
  output logic [31:0] out_3_o,
  output logic [31:0] out_4_o,
  output logic [31:0] out_5_o,
  output logic [31:0] out_6_o,
  output logic [31:0] out_7_o,
  output logic [31:0] out_8_o,
  output logic [1:0]  load_status_o,
  output logic [1:0]  query_range_o
);

  // one-hot sequencer states
  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_LOAD = 12'b0000_0000_0010,
    ST_QCHK = 12'b0000_0000_0100,
    ST_SRD  = 12'b0000_0000_1000,
    ST_SCMP = 12'b0000_0001_0000,
    ST_DIV  = 12'b0000_0010_0000,
    ST_LRD0 = 12'b0000_0100_0000,
    ST_LRD1 = 12'b0000_1000_0000,
    ST_LCAP = 12'b0001_0000_0000,
    ST_LMUL = 12'b0010_0000_0000,
    ST_LADD = 12'b0100_0000_0000,
    ST_FIN  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // accepted beat
  logic                             op_q;
  logic signed [pli_pkg::VAL_W-1:0] t_q;
  logic [pli_pkg::VAL_W-1:0]        comp_q [pli_pkg::MAX_COMP];
  logic [pli_pkg::VAL_W-1:0]        comp_in [pli_pkg::MAX_COMP];

  // table bookkeeping
  logic [pli_pkg::CNT_W-1:0]        count_q, count_d;
  logic signed [pli_pkg::VAL_W-1:0] first_q, last_q;
  logic [pli_pkg::IDX_W-1:0]        tail_idx;

  // search window: s[lo] <= t < s[hi]
  logic [pli_pkg::IDX_W-1:0]        lo_q, hi_q, mid_q, idx0_q, idx1_q;
  logic [pli_pkg::CNT_W-1:0]        lo_sum, lo_inc;
  logic signed [pli_pkg::VAL_W-1:0] slo_q, shi_q;
  logic [pli_pkg::VAL_W-1:0]        srd;
  logic signed [pli_pkg::VAL_W-1:0] srd_s;
  logic                             search_more;

  // interpolation
  logic [pli_pkg::FRAC_BITS-1:0]    frac_q, quo;
  logic                             div_start, div_done;
  logic [pli_pkg::DIFF_W-1:0]       div_num, div_den;
  logic                             zero_q;
  logic [1:0]                       status_q, range_q;
  pli_pkg::lane_ctrl_t              lctrl;
  logic [pli_pkg::VAL_W-1:0]        lane_res [pli_pkg::MAX_COMP];

  // output register
  logic                             ovalid_q;
  logic [pli_pkg::VAL_W-1:0]        out_q [pli_pkg::MAX_COMP];
  logic [1:0]                       ostat_q, orange_q;
  logic                             out_free, in_acc;

  assign comp_in = '{comp_0_i, comp_1_i, comp_2_i, comp_3_i, comp_4_i,
                     comp_5_i, comp_6_i, comp_7_i, comp_8_i};

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ovalid_q || !out_stall_i;
  assign tail_idx   = pli_pkg::IDX_W'(count_q - 1'b1);

  assign lo_sum      = pli_pkg::CNT_W'(lo_q) + pli_pkg::CNT_W'(hi_q);
  assign lo_inc      = pli_pkg::CNT_W'(lo_q) + 1'b1;
  assign search_more = pli_pkg::CNT_W'(hi_q) > lo_inc;
  assign srd_s       = srd;

  // stamp memory, write on a stored load, read during the search
  pli_ram #(
    .WIDTH (pli_pkg::VAL_W),
    .DEPTH (pli_pkg::TABLE_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (lctrl.we),
    .waddr_i (lctrl.waddr),
    .wdata_i (t_q),
    .raddr_i (lo_sum[pli_pkg::IDX_W:1]),
    .rdata_o (srd)
  );

  // fraction numerator and segment length, both non-negative
  assign div_num = pli_pkg::DIFF_W'(t_q) - pli_pkg::DIFF_W'(slo_q);
  assign div_den = pli_pkg::DIFF_W'(shi_q) - pli_pkg::DIFF_W'(slo_q);

  pli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // lane control decode
  always_comb begin
    lctrl.we    = 1'b0;
    lctrl.waddr = count_q[pli_pkg::IDX_W-1:0];
    lctrl.raddr = (state_q == ST_LRD0) ? idx0_q : idx1_q;
    lctrl.cap0  = state_q == ST_LRD1;
    lctrl.cap1  = state_q == ST_LCAP;
    lctrl.mul   = state_q == ST_LMUL;
    lctrl.fin   = state_q == ST_LADD;
    if (state_q == ST_LOAD && !(count_q != '0 && t_q <= last_q) &&
        count_q != pli_pkg::CNT_W'(pli_pkg::TABLE_DEPTH)) begin
      lctrl.we = 1'b1;
    end
  end

  assign div_start = (state_q == ST_SRD) && !search_more;

  // component lanes side by side, unused components read as zero
  for (genvar k = 0; k < pli_pkg::MAX_COMP; k++) begin : g_lane
    if (k < pli_pkg::COMPONENTS) begin : g_used
      pli_lane u_lane (
        .clk_i   (clk_i),
        .ctrl_i  (lctrl),
        .wdata_i (comp_q[k]),
        .frac_i  (frac_q),
        .res_o   (lane_res[k])
      );
    end else begin : g_unused
      assign lane_res[k] = '0;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = (op_i == pli_pkg::OP_QUERY) ? ST_QCHK : ST_LOAD;
      ST_LOAD: begin
        state_d = ST_FIN;
        if (lctrl.we) count_d = count_q + 1'b1;
      end
      ST_QCHK: begin
        priority if (count_q == '0)      state_d = ST_FIN;
        else if (t_q < first_q)          state_d = ST_LRD0;
        else if (t_q >= last_q)          state_d = ST_LRD0;
        else                             state_d = ST_SRD;
      end
      ST_SRD:  state_d = search_more ? ST_SCMP : ST_DIV;
      ST_SCMP: state_d = ST_SRD;
      ST_DIV:  if (div_done) state_d = ST_LRD0;
      ST_LRD0: state_d = ST_LRD1;
      ST_LRD1: state_d = ST_LCAP;
      ST_LCAP: state_d = ST_LMUL;
      ST_LMUL: state_d = ST_LADD;
      ST_LADD: state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == ST_FIN && out_free) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= op_i;
      t_q  <= stamp_i;
      for (int k = 0; k < pli_pkg::MAX_COMP; k++) comp_q[k] <= comp_in[k];
      zero_q   <= 1'b0;
      status_q <= pli_pkg::LS_STORED;
      range_q  <= pli_pkg::QR_INSIDE;
    end
    unique case (state_q)
      ST_LOAD: begin
        zero_q <= 1'b1;
        priority if (count_q != '0 && t_q <= last_q) begin
          status_q <= pli_pkg::LS_SKIP;
        end else if (count_q == pli_pkg::CNT_W'(pli_pkg::TABLE_DEPTH)) begin
          status_q <= pli_pkg::LS_FULL;
        end else begin
          last_q <= t_q;
          if (count_q == '0) first_q <= t_q;
        end
      end
      ST_QCHK: begin
        frac_q <= '0;
        priority if (count_q == '0) begin
          zero_q  <= 1'b1;
          range_q <= pli_pkg::QR_EMPTY;
        end else if (t_q < first_q) begin
          idx0_q  <= '0;
          idx1_q  <= '0;
          range_q <= pli_pkg::QR_LOW;
        end else if (t_q >= last_q) begin
          idx0_q <= tail_idx;
          idx1_q <= tail_idx;
          if (t_q != last_q) range_q <= pli_pkg::QR_HIGH;
        end else begin
          lo_q  <= '0;
          hi_q  <= tail_idx;
          slo_q <= first_q;
          shi_q <= last_q;
        end
      end
      ST_SRD: mid_q <= lo_sum[pli_pkg::IDX_W:1];
      ST_SCMP: begin
        if (srd_s <= t_q) begin
          lo_q  <= mid_q;
          slo_q <= srd_s;
        end else begin
          hi_q  <= mid_q;
          shi_q <= srd_s;
        end
      end
      ST_DIV: begin
        idx0_q <= lo_q;
        idx1_q <= lo_inc[pli_pkg::IDX_W-1:0];
        if (div_done) frac_q <= quo;
      end
      ST_FIN: begin
        if (out_free) begin
          for (int k = 0; k < pli_pkg::MAX_COMP; k++) begin
            out_q[k] <= zero_q ? '0 : lane_res[k];
          end
          ostat_q  <= (op_q == pli_pkg::OP_LOAD) ? status_q : 2'(pli_pkg::LS_STORED);
          orange_q <= (op_q == pli_pkg::OP_QUERY) ? range_q : 2'(pli_pkg::QR_INSIDE);
        end
      end
      default: ;
    endcase
  end

  // merged result beat
  assign out_valid_o   = ovalid_q;
  assign out_0_o       = out_q[0];
  assign out_1_o       = out_q[1];
  assign out_2_o       = out_q[2];
  assign out_3_o       = out_q[3];
  assign out_4_o       = out_q[4];
  assign out_5_o       = out_q[5];
  assign out_6_o       = out_q[6];
  assign out_7_o       = out_q[7];
  assign out_8_o       = out_q[8];
  assign load_status_o = ostat_q;
  assign query_range_o = orange_q;

endmodule

// ===== sv/pli_chk.sv =====
// ---------------------------------------------------------------------------
// pli_chk
// port level checks of the interpolator, bound to the top level
// ---------------------------------------------------------------------------
module pli_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_0_o,
  input logic [1:0]  load_status_o,
  input logic [1:0]  query_range_o
);

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_0_o))
    else $error("stalled result beat changed");

  a_one_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> load_status_o == pli_pkg::LS_STORED ||
                    query_range_o == pli_pkg::QR_INSIDE)
    else $error("load and query codes both set");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> load_status_o != 2'd3)
    else $error("undefined load status");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && query_range_o == pli_pkg::QR_EMPTY |-> out_0_o == '0)
    else $error("empty table query gave a value");

endmodule

bind piecewise_linear_table_interp_core pli_chk u_pli_chk (.*);

// ===== sim/pli_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pli_checker
// watches both channels of the table interpolator, predicts each result beat
// and compares it field by field
// ---------------------------------------------------------------------------
module pli_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        op_i,
  input  logic [31:0] stamp_i,
  input  logic [31:0] comp_i [9],
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] out_i [9],
  input  logic [1:0]  load_status_i,
  input  logic [1:0]  query_range_i,
  output int          errors_o,
  output int          pending_o,
  output int          loads_o,
  output int          queries_o
);

  typedef struct {
    logic [31:0]           val [9];
    pli_pkg::load_status_e ls;
    pli_pkg::query_range_e qr;
  } result_t;

  logic signed [31:0] tbl_stamp [pli_pkg::TABLE_DEPTH];
  logic signed [31:0] tbl_val   [pli_pkg::TABLE_DEPTH][pli_pkg::COMPONENTS];
  int                 tbl_count;
  result_t            expected_q [$];

  // floor of a signed product shifted down by the fraction width
  function automatic longint lerp(longint v0, longint v1, longint f);
    longint p;
    p = f * (v1 - v0);
    return v0 + (p >>> pli_pkg::FRAC_BITS);
  endfunction

  function automatic result_t table_step(logic op, logic signed [31:0] t,
                                         logic [31:0] c [9]);
    result_t r;
    int      seg;
    longint  f;
    for (int k = 0; k < 9; k++) r.val[k] = '0;
    r.ls = pli_pkg::LS_STORED;
    r.qr = pli_pkg::QR_INSIDE;
    if (op == pli_pkg::OP_LOAD) begin
      if (tbl_count > 0 && t <= tbl_stamp[tbl_count-1]) begin
        r.ls = pli_pkg::LS_SKIP;
      end else if (tbl_count >= pli_pkg::TABLE_DEPTH) begin
        r.ls = pli_pkg::LS_FULL;
      end else begin
        tbl_stamp[tbl_count] = t;
        for (int k = 0; k < pli_pkg::COMPONENTS; k++) tbl_val[tbl_count][k] = c[k];
        tbl_count++;
      end
      return r;
    end
    if (tbl_count == 0) begin
      r.qr = pli_pkg::QR_EMPTY;
      return r;
    end
    seg = -1;
    if (t < tbl_stamp[0]) begin
      r.qr = pli_pkg::QR_LOW;
      for (int k = 0; k < pli_pkg::COMPONENTS; k++) r.val[k] = tbl_val[0][k];
    end else if (t >= tbl_stamp[tbl_count-1]) begin
      if (t != tbl_stamp[tbl_count-1]) r.qr = pli_pkg::QR_HIGH;
      for (int k = 0; k < pli_pkg::COMPONENTS; k++) r.val[k] = tbl_val[tbl_count-1][k];
    end else begin
      for (int i = 0; i < tbl_count - 1; i++)
        if (t >= tbl_stamp[i] && t < tbl_stamp[i+1]) seg = i;
      f = ((longint'(t) - tbl_stamp[seg]) <<< pli_pkg::FRAC_BITS)
          / (longint'(tbl_stamp[seg+1]) - tbl_stamp[seg]);
      for (int k = 0; k < pli_pkg::COMPONENTS; k++)
        r.val[k] = 32'(lerp(tbl_val[seg][k], tbl_val[seg+1][k], f));
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      tbl_count = 0;
      expected_q.delete();
      errors_o  = 0;
      loads_o   = 0;
      queries_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        e = table_step(op_i, stamp_i, comp_i);
        expected_q.insert(expected_q.size(), e);
        if (op_i == pli_pkg::OP_LOAD) loads_o++;
        else queries_o++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat", $time);
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (out_i[k] !== e.val[k]) begin
              $display("%0t: out_%0d expected %h actual %h", $time, k, e.val[k],
                       out_i[k]);
              errors_o++;
            end
          if (load_status_i !== e.ls) begin
            $display("%0t: load_status expected %0d actual %0d", $time, e.ls,
                     load_status_i);
            errors_o++;
          end
          if (query_range_i !== e.qr) begin
            $display("%0t: query_range expected %0d actual %0d", $time, e.qr,
                     query_range_i);
            errors_o++;
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// stimulus and verdict for the piecewise linear table interpolator: fills
// the table with ascending stamps, queries inside and outside it, never
// resets the table after start but appends in each run, under random idling
// ---------------------------------------------------------------------------
module tb;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [31:0] stamp;
  logic [31:0] comp [9];
  logic        out_valid;
  logic        out_stall;
  logic [31:0] outv [9];
  logic [1:0]  load_status;
  logic [1:0]  query_range;
  int          errors, pending, n_loads, n_queries;

  // idle rates in percent, switched per phase
  int          send_idle;
  int          recv_idle;
  int          hold_cycles;
  logic signed [31:0] last_stamp;
  int          stored;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  piecewise_linear_table_interp_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .stamp_i(stamp),
    .comp_0_i(comp[0]), .comp_1_i(comp[1]), .comp_2_i(comp[2]),
    .comp_3_i(comp[3]), .comp_4_i(comp[4]), .comp_5_i(comp[5]),
    .comp_6_i(comp[6]), .comp_7_i(comp[7]), .comp_8_i(comp[8]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_0_o(outv[0]), .out_1_o(outv[1]), .out_2_o(outv[2]),
    .out_3_o(outv[3]), .out_4_o(outv[4]), .out_5_o(outv[5]),
    .out_6_o(outv[6]), .out_7_o(outv[7]), .out_8_o(outv[8]),
    .load_status_o(load_status), .query_range_o(query_range)
  );

  pli_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .op_i(op), .stamp_i(stamp), .comp_i(comp),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_i(outv), .load_status_i(load_status), .query_range_i(query_range),
    .errors_o(errors), .pending_o(pending),
    .loads_o(n_loads), .queries_o(n_queries)
  );

  // receiver stall: random rate, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // one beat on the input channel, with random idle cycles first; valid is
  // dropped by the next beat's idling or by drain
  task automatic send_beat(logic o, logic [31:0] t, logic [31:0] c [9]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    stamp    <= t;
    for (int k = 0; k < 9; k++) comp[k] <= c[k];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_load(logic [31:0] t);
    logic [31:0] c [9];
    for (int k = 0; k < 9; k++) c[k] = rand_word();
    send_beat(pli_pkg::OP_LOAD, t, c);
  endtask

  task automatic send_query(logic [31:0] t);
    logic [31:0] c [9];
    for (int k = 0; k < 9; k++) c[k] = $urandom;
    send_beat(pli_pkg::OP_QUERY, t, c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // a fresh table is impossible without reset, so each random run appends
  // ascending stamps above the last stored one and queries across the table
  task automatic random_run(int n);
    logic signed [31:0] t;
    logic signed [31:0] lo;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0 && stored < pli_pkg::TABLE_DEPTH + 4) begin
        if ($urandom_range(7) == 0) t = last_stamp - $urandom_range(3);
        else if (last_stamp > 32'sh7000_0000) t = last_stamp + 1;
        else t = last_stamp + $urandom_range(1, 32'h0100_0000);
        if (t > last_stamp) begin
          last_stamp = t;
          stored++;
        end
        send_load(t);
      end else begin
        lo = $urandom;
        case ($urandom_range(4))
          0: send_query(lo);
          1: send_query(last_stamp + $urandom_range(2) - 1);
          default: send_query(32'sh8000_1000 + $urandom_range(32'h7fff_ffff) +
                              $urandom_range(32'h7fff_0000));
        endcase
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("** piecewise_linear_table_interp_core: FAILED **");
    $finish;
  end

  initial begin
    logic [31:0] z [9];
    logic [31:0] t;
    for (int k = 0; k < 9; k++) z[k] = '0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    op          = pli_pkg::OP_LOAD;
    stamp       = '0;
    for (int k = 0; k < 9; k++) comp[k] = '0;
    out_stall   = 1'b0;
    hold_cycles = 0;
    send_idle   = 0;
    recv_idle   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, first load at the lowest stamp, single entry
    send_query(32'h0);
    send_load(32'h8000_0000);
    send_query(32'h8000_0000);
    send_query(32'h0001_0000);
    send_load(32'h8000_0000);                 // equal stamp is skipped
    send_beat(pli_pkg::OP_LOAD, 32'h8001_0000, '{default: 32'h8000_0000});
    send_beat(pli_pkg::OP_LOAD, 32'h0000_0000, '{default: 32'h7fff_ffff});
    send_query(32'h8000_8000);                // inside, extreme values
    send_query(32'hc000_0000);
    send_query(32'hffff_ffff);
    send_query(32'h0000_0000);                // exactly last stamp
    send_query(32'h7fff_ffff);                // above range
    send_load(32'h8000_0001);                 // below last stamp
    last_stamp = 32'sh0000_0000;
    stored     = 3;
    drain();

    // pressure: long receiver hold-off while items keep coming
    hold_cycles <= 300;
    random_run(20);
    drain();

    send_idle = 27; recv_idle = 69;
    random_run(330);
    drain();
    send_idle = 69; recv_idle = 27;
    random_run(330);
    drain();
    send_idle = 0; recv_idle = 0;
    random_run(250);
    // fill the table to the top and beyond, then extremes
    for (int i = 0; i < pli_pkg::TABLE_DEPTH + 3; i++) begin
      t = (last_stamp < 32'sh7fff_fff0) ? last_stamp + 1 : 32'h7fff_ffff;
      if (t != last_stamp) last_stamp = t;
      send_load(t);
    end
    send_load(32'h7fff_ffff);
    send_query(32'h7fff_ffff);
    send_query(32'h8000_0000);
    drain();
    repeat (60) @(posedge clk);

    $display("run covered %0d loads and %0d queries, table filled to full",
             n_loads, n_queries);
    if (errors == 0 && pending == 0) begin
      $display("** piecewise_linear_table_interp_core: PASSED **");
    end else begin
      $display("** piecewise_linear_table_interp_core: FAILED **");
    end
    $finish;
  end

endmodule
